### rtl/core/refcounted_lock_slot_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lock slot table
// Concurrent checks clocked on clk_i, with reset rst_ni disabling them.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_LOCK_SLOT_TABLE_ASSERT_SVH
`define REFCOUNTED_LOCK_SLOT_TABLE_ASSERT_SVH

`ifndef SYNTH
// Checks a property on every rising clock edge outside reset.
`define RLST_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rlst assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define RLST_ASSERT_NEXT(name, ante, cons) \
  `RLST_ASSERT(name, (ante) |=> (cons))
`else
`define RLST_ASSERT(name, prop)
`define RLST_ASSERT_NEXT(name, ante, cons)
`endif

`endif

### rtl/core/rlst_pkg.sv
// ----------------------------------------------------------------------------
// rlst_pkg
// Types, codes and sizes shared by the lock slot table modules.
// ----------------------------------------------------------------------------
package rlst_pkg;

  localparam int SLOTS   = 16;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int N_W     = $clog2(SLOTS + 1);
  localparam int CFG_W   = 5;
  localparam int FUNC_W  = 2;
  localparam int ID_W    = 32;
  localparam int STAT_W  = 2;
  localparam int SLOT_W  = 4;
  localparam int COUNT_W = 16;

  localparam logic [CFG_W-1:0]   CFG_RESET   = CFG_W'(16);
  localparam logic [ID_W-1:0]    FILEID_FREE = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

  localparam logic [FUNC_W-1:0] FUNC_LOCK_RD  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOCK_WR  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_INVALID  = 2'd3;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } rlst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } rlst_stat_t;

endpackage

### rtl/core/rlst_req_if.sv
// ----------------------------------------------------------------------------
// rlst_req_if
// Request channel: lock or release of one file identifier.
// ----------------------------------------------------------------------------
interface rlst_req_if import rlst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ID_W-1:0]   file_id;

  modport source (output valid, output func, output file_id, input ready);
  modport sink   (input valid, input func, input file_id, output ready);
endinterface

### rtl/core/rlst_rsp_if.sv
// ----------------------------------------------------------------------------
// rlst_rsp_if
// Response channel: status, slot and count of one request.
// ----------------------------------------------------------------------------
interface rlst_rsp_if import rlst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [SLOT_W-1:0]  slot;
  logic [COUNT_W-1:0] count_after;
  logic [FUNC_W-1:0]  lock_kind;

  modport source (output valid, output status, output slot, output count_after,
                  output lock_kind, input ready);
  modport sink   (input valid, input status, input slot, input count_after,
                  input lock_kind, output ready);
endinterface

### rtl/core/rlst_ctrl.sv
// ----------------------------------------------------------------------------
// rlst_ctrl
// Sequencer: takes a request, steps the slot scan, then commits the result.
// ----------------------------------------------------------------------------
module rlst_ctrl import rlst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  rlst_stat_t stat_i,
  output rlst_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            state_q <= S_SCAN;
            ready_q <= 1'b0;
          end
        end
        S_SCAN: begin
          if (stat_i.scan_done) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          // The result waits here until the output register can take it.
          if (stat_i.out_free) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign req_ready_o  = ready_q;
  assign cmd_o.load   = ready_q && req_valid_i;
  assign cmd_o.step   = (state_q == S_SCAN);
  assign cmd_o.commit = (state_q == S_FINISH) && stat_i.out_free;

endmodule

### rtl/core/rlst_dp.sv
// ----------------------------------------------------------------------------
// rlst_dp
// Slot table, scan registers, update logic and the output register.
// ----------------------------------------------------------------------------
`include "refcounted_lock_slot_table_assert.svh"

module rlst_dp import rlst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic [FUNC_W-1:0]  req_func_i,
  input  logic [ID_W-1:0]    req_file_id_i,
  input  rlst_cmd_t          cmd_i,
  output rlst_stat_t         stat_o,
  output logic               rsp_valid_o,
  input  logic               rsp_ready_i,
  output logic [STAT_W-1:0]  rsp_status_o,
  output logic [SLOT_W-1:0]  rsp_slot_o,
  output logic [COUNT_W-1:0] rsp_count_after_o,
  output logic [FUNC_W-1:0]  rsp_lock_kind_o
);

  logic [CFG_W-1:0]   cfg_q;
  logic [ID_W-1:0]    fid_q [SLOTS];
  logic [COUNT_W-1:0] cnt_q [SLOTS];

  logic [FUNC_W-1:0]  func_q;
  logic [ID_W-1:0]    id_q;
  logic [IDX_W-1:0]   idx_q;
  logic               have_match_q;
  logic               have_free_q;
  logic [IDX_W-1:0]   match_idx_q;
  logic [IDX_W-1:0]   free_idx_q;
  logic [COUNT_W-1:0] match_cnt_q;

  logic               out_valid_q;
  status_e            status_q;
  logic [SLOT_W-1:0]  slot_q;
  logic [COUNT_W-1:0] count_q;
  logic [FUNC_W-1:0]  kind_q;

  logic [N_W-1:0]     n;
  logic               bad_req;
  logic               skip;
  logic               entry_free;
  logic               entry_hit;
  logic               idx_last;
  logic               out_free;

  status_e            res_status;
  logic [IDX_W-1:0]   res_idx;
  logic [COUNT_W-1:0] res_count;
  logic               wr_en;
  logic [ID_W-1:0]    wr_fid;
  logic [COUNT_W-1:0] wr_cnt;
  logic [COUNT_W-1:0] dec_cnt;

  // A register value above the table size searches the whole table.
  always_comb begin
    if (int'(cfg_q) > SLOTS) begin
      n = N_W'(SLOTS);
    end else begin
      n = N_W'(cfg_q);
    end
  end

  assign bad_req = (func_q == FUNC_INVALID) || (id_q == FILEID_FREE);
  // An empty table ends the scan at once; the lock then finds no free slot.
  assign skip    = bad_req || (n == '0);

  assign entry_free = (fid_q[idx_q] == FILEID_FREE);
  assign entry_hit  = !entry_free && (fid_q[idx_q] == id_q);
  assign idx_last   = (int'(idx_q) == int'(n) - 1);
  assign out_free   = !out_valid_q || rsp_ready_i;

  assign stat_o.scan_done = skip || entry_hit || idx_last;
  assign stat_o.out_free  = out_free;

  assign dec_cnt = (match_cnt_q == '0) ? '0 : match_cnt_q - COUNT_W'(1);

  always_comb begin
    res_status = ST_NOTFOUND;
    res_idx    = '0;
    res_count  = '0;
    wr_en      = 1'b0;
    wr_fid     = id_q;
    wr_cnt     = '0;
    if (!bad_req) begin
      if (func_q == FUNC_RELEASE) begin
        if (have_match_q) begin
          res_status = ST_OK;
          res_idx    = match_idx_q;
          res_count  = dec_cnt;
          wr_en      = 1'b1;
          wr_cnt     = dec_cnt;
          // The last release frees the slot.
          wr_fid     = (dec_cnt == '0) ? FILEID_FREE : id_q;
        end
      end else if (have_match_q) begin
        res_idx = match_idx_q;
        if (match_cnt_q == COUNT_MAX) begin
          res_status = ST_OVERFLOW;
          res_count  = COUNT_MAX;
        end else begin
          res_status = ST_OK;
          res_count  = match_cnt_q + COUNT_W'(1);
          wr_en      = 1'b1;
          wr_cnt     = match_cnt_q + COUNT_W'(1);
        end
      end else if (have_free_q) begin
        res_status = ST_OK;
        res_idx    = free_idx_q;
        res_count  = COUNT_W'(1);
        wr_en      = 1'b1;
        wr_cnt     = COUNT_W'(1);
      end else begin
        res_status = ST_FULL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CFG_RESET;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        fid_q[i] <= FILEID_FREE;
        cnt_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.commit && wr_en) begin
        fid_q[res_idx] <= wr_fid;
        cnt_q[res_idx] <= wr_cnt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q       <= req_func_i;
      id_q         <= req_file_id_i;
      idx_q        <= '0;
      have_match_q <= 1'b0;
      have_free_q  <= 1'b0;
    end else if (cmd_i.step && !skip) begin
      if (entry_free && !have_free_q) begin
        have_free_q <= 1'b1;
        free_idx_q  <= idx_q;
      end
      if (entry_hit) begin
        have_match_q <= 1'b1;
        match_idx_q  <= idx_q;
        match_cnt_q  <= cnt_q[idx_q];
      end
      if (!idx_last) begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
    if (cmd_i.commit) begin
      status_q <= res_status;
      slot_q   <= SLOT_W'(res_idx);
      count_q  <= res_count;
      kind_q   <= func_q;
    end
  end

  assign rsp_valid_o       = out_valid_q;
  assign rsp_status_o      = status_q;
  assign rsp_slot_o        = slot_q;
  assign rsp_count_after_o = count_q;
  assign rsp_lock_kind_o   = kind_q;

  `RLST_ASSERT(a_commit_needs_room, cmd_i.commit |-> out_free)
  `RLST_ASSERT_NEXT(a_commit_shows_item, cmd_i.commit, out_valid_q)
  `RLST_ASSERT(a_scan_in_range, (cmd_i.step && !skip) |-> (int'(idx_q) < int'(n)))
  `RLST_ASSERT(a_no_match_on_bad_req, (cmd_i.commit && skip) |-> !wr_en)

endmodule

### rtl/core/refcounted_lock_slot_table.sv
// ----------------------------------------------------------------------------
// refcounted_lock_slot_table
// Table of reference-counted lock slots keyed by file identifier.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                  accepted when
//  req_i    in   func, file_id                            valid && ready
//  rsp_o    out  status, slot, count_after, lock_kind     valid && ready
//  cfg      in   slots_in_use (5 bits)                    cfg_we_i
//
// An item is accepted, the scan of the identifier store visits slot after
// slot up to n, the active slot count (at most 16), and the result is then
// committed. A hit ends the scan early; a reserved identifier, func 3 or an
// empty table ends the scan at once. Reset frees every slot at once. A
// stalled result holds the commit until the output register drains.
// ----------------------------------------------------------------------------
module refcounted_lock_slot_table import rlst_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  rlst_req_if.sink         req_i,
  rlst_rsp_if.source       rsp_o
);

  rlst_cmd_t  cmd;
  rlst_stat_t stat;

  rlst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rlst_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .req_func_i        (req_i.func),
    .req_file_id_i     (req_i.file_id),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_status_o      (rsp_o.status),
    .rsp_slot_o        (rsp_o.slot),
    .rsp_count_after_o (rsp_o.count_after),
    .rsp_lock_kind_o   (rsp_o.lock_kind)
  );

endmodule

### tb/rlst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlst_checker
// Watches the request, response and register ports of the lock slot table,
// keeps its own copy of the slot table to predict every response, and
// compares each accepted response with the oldest prediction.
// ----------------------------------------------------------------------------
module rlst_checker import rlst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic               req_valid_i,
  input  logic               req_ready_i,
  input  logic [FUNC_W-1:0]  req_func_i,
  input  logic [ID_W-1:0]    req_file_id_i,
  input  logic               rsp_valid_i,
  input  logic               rsp_ready_i,
  input  logic [STAT_W-1:0]  rsp_status_i,
  input  logic [SLOT_W-1:0]  rsp_slot_i,
  input  logic [COUNT_W-1:0] rsp_count_i,
  input  logic [FUNC_W-1:0]  rsp_kind_i,
  output int                 pending_o,
  output int                 fail_count_o
);

  typedef struct packed {
    status_e            status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count_after;
    logic [FUNC_W-1:0]  lock_kind;
  } lock_result_t;

  logic [ID_W-1:0]    id_store [SLOTS];
  logic [COUNT_W-1:0] use_count [SLOTS];
  logic [CFG_W-1:0]   active_slots;
  lock_result_t       awaited_q [$];

  initial fail_count_o = 0;

  // Applies one request to the local table and returns the response it
  // should produce.
  function automatic lock_result_t resolve_request(logic [FUNC_W-1:0] func,
                                                   logic [ID_W-1:0] id);
    lock_result_t r;
    int n;
    int hit;
    int vacant;
    logic [COUNT_W-1:0] cnt;
    r.status      = ST_NOTFOUND;
    r.slot        = '0;
    r.count_after = '0;
    r.lock_kind   = func;
    if (func == FUNC_INVALID || id == FILEID_FREE) return r;

    n = (int'(active_slots) > SLOTS) ? SLOTS : int'(active_slots);
    hit = -1;
    vacant = -1;
    // The scan stops at the first hit; only free slots ahead of it count.
    for (int i = 0; i < n && hit < 0; i++) begin
      if (id_store[i] == FILEID_FREE) begin
        if (vacant < 0) vacant = i;
      end else if (id_store[i] == id) begin
        hit = i;
      end
    end

    if (func == FUNC_RELEASE) begin
      if (hit < 0) return r;
      cnt = (use_count[hit] == '0) ? '0 : use_count[hit] - 1'b1;
      use_count[hit] = cnt;
      if (cnt == '0) id_store[hit] = FILEID_FREE;
      r.status      = ST_OK;
      r.slot        = SLOT_W'(hit);
      r.count_after = cnt;
    end else if (hit >= 0) begin
      r.slot = SLOT_W'(hit);
      if (use_count[hit] == COUNT_MAX) begin
        r.status      = ST_OVERFLOW;
        r.count_after = COUNT_MAX;
      end else begin
        use_count[hit] = use_count[hit] + 1'b1;
        r.status       = ST_OK;
        r.count_after  = use_count[hit];
      end
    end else if (vacant < 0) begin
      r.status = ST_FULL;
    end else begin
      id_store[vacant]  = id;
      use_count[vacant] = COUNT_W'(1);
      r.status          = ST_OK;
      r.slot            = SLOT_W'(vacant);
      r.count_after     = COUNT_W'(1);
    end
    return r;
  endfunction

  function automatic void note_mismatch(string field, logic [31:0] want,
                                        logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    fail_count_o++;
  endfunction

  task automatic check_result();
    lock_result_t want;
    if (awaited_q.size() == 0) begin
      $display("%0t: response with no request waiting, status %0h slot %0h count %0h kind %0h",
               $time, rsp_status_i, rsp_slot_i, rsp_count_i, rsp_kind_i);
      fail_count_o++;
    end else begin
      want = awaited_q.pop_front();
      if (rsp_status_i !== want.status) note_mismatch("status", want.status, rsp_status_i);
      if (rsp_slot_i !== want.slot) note_mismatch("slot", want.slot, rsp_slot_i);
      if (rsp_count_i !== want.count_after)
        note_mismatch("count_after", want.count_after, rsp_count_i);
      if (rsp_kind_i !== want.lock_kind)
        note_mismatch("lock_kind", want.lock_kind, rsp_kind_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        id_store[i]  = FILEID_FREE;
        use_count[i] = '0;
      end
      active_slots = CFG_RESET;
      awaited_q.delete();
      pending_o = 0;
    end else begin
      // A response comes only after its request's scan and commit, so one accepted
      // on this edge never belongs to the request accepted on it.
      if (rsp_valid_i && rsp_ready_i) check_result();
      if (req_valid_i && req_ready_i)
        awaited_q.push_back(resolve_request(req_func_i, req_file_id_i));
      if (cfg_we_i) active_slots = cfg_wdata_i;
      pending_o = awaited_q.size();
    end
  end

endmodule

### tb/refcounted_lock_slot_table_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_lock_slot_table_tb
// Drives lock and release requests into the slot table under several table
// sizes and handshake stall patterns: a one-slot run, a directed pass over
// the corner cases, then random traffic over small id pools.
// ----------------------------------------------------------------------------
module refcounted_lock_slot_table_tb;
  import rlst_pkg::*;

  localparam int PHASES     = 12;
  localparam int PHASE_REQS = 134;
  localparam int POOL_MAX   = 20;
  localparam int SETTLE     = 24;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int               send_idle;
  int               recv_idle;
  int               pending;
  int               fails;

  rlst_req_if req_if ();
  rlst_rsp_if rsp_if ();

  refcounted_lock_slot_table DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  rlst_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .req_valid_i   (req_if.valid),
    .req_ready_i   (req_if.ready),
    .req_func_i    (req_if.func),
    .req_file_id_i (req_if.file_id),
    .rsp_valid_i   (rsp_if.valid),
    .rsp_ready_i   (rsp_if.ready),
    .rsp_status_i  (rsp_if.status),
    .rsp_slot_i    (rsp_if.slot),
    .rsp_count_i   (rsp_if.count_after),
    .rsp_kind_i    (rsp_if.lock_kind),
    .pending_o     (pending),
    .fail_count_o  (fails)
  );

  always #5ns clk_i = ~clk_i;

  initial begin
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    req_if.valid   = 1'b0;
    req_if.func    = FUNC_LOCK_RD;
    req_if.file_id = '0;
    rsp_if.ready   = 1'b0;
    send_idle      = 0;
    recv_idle      = 0;
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= recv_idle);
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so back-to-back requests never toggle it.
  task automatic send_request(logic [FUNC_W-1:0] func, logic [ID_W-1:0] id);
    while ($urandom_range(99) < send_idle) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.func    <= func;
    req_if.file_id <= id;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_slots(logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    logic [ID_W-1:0]  pool [POOL_MAX];
    logic [CFG_W-1:0] phase_slots [8];
    logic [ID_W-1:0]  id;
    logic [FUNC_W-1:0] func;
    int pool_n;
    int pick;

    phase_slots = '{5'd16, 5'd3, 5'd0, 5'd31, 5'd1, 5'd17, 5'd8, 5'd16};
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // One-slot table: repeated locks count up, a release steps the count
    // down, and a second identifier finds the table full.
    write_slots(5'd1);
    send_request(FUNC_LOCK_RD, '0);
    send_request(FUNC_LOCK_WR, '0);
    send_request(FUNC_RELEASE, '0);
    send_request(FUNC_LOCK_RD, 32'h0000_0001);
    send_request(FUNC_RELEASE, 32'h0000_0001);
    settle();

    write_slots(5'd16);
    send_request(FUNC_LOCK_WR, 32'hFFFF_FFFE);
    send_request(FUNC_LOCK_RD, FILEID_FREE);
    send_request(FUNC_INVALID, 32'h0000_1234);
    send_request(FUNC_INVALID, FILEID_FREE);
    send_request(FUNC_RELEASE, FILEID_FREE);
    send_request(FUNC_LOCK_RD, 32'hA5A5_5A5A);
    send_request(FUNC_RELEASE, 32'hFFFF_FFFE);
    send_request(FUNC_RELEASE, 32'hFFFF_FFFE);
    // Fill every remaining slot, then one more lock finds the table full.
    for (int k = 0; k < 14; k++) send_request(FUNC_LOCK_RD, 32'h100 + k);
    send_request(FUNC_LOCK_WR, 32'hDEAD_BEEF);
    settle();

    // A zero-sized table searches nothing.
    write_slots(5'd0);
    send_request(FUNC_LOCK_RD, 32'h100);
    send_request(FUNC_RELEASE, 32'h100);
    settle();

    // Oversized setting behaves like the full table.
    write_slots(5'd31);
    send_request(FUNC_RELEASE, 32'h10D);
    send_request(FUNC_LOCK_WR, 32'h10D);
    settle();

    // Shrunk table: upper slots keep their ids but are not visible.
    write_slots(5'd4);
    send_request(FUNC_LOCK_RD, 32'h5555_AAAA);
    send_request(FUNC_RELEASE, 32'h10C);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 4) begin
        send_idle = 35;
        recv_idle = 83;
      end else if (p < 8) begin
        send_idle = 83;
        recv_idle = 35;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_slots((p < 8) ? phase_slots[p] : CFG_W'($urandom_range(31)));
      pool_n = $urandom_range(POOL_MAX, 2);
      for (int k = 0; k < POOL_MAX; k++) begin
        pool[k] = $urandom();
        if (pool[k] == FILEID_FREE) pool[k] = 32'hFFFF_FFFE;
      end

      for (int k = 0; k < PHASE_REQS; k++) begin
        pick = $urandom_range(99);
        if (pick < 85) begin
          id = pool[$urandom_range(pool_n - 1)];
          if ($urandom_range(99) < 55)
            func = $urandom_range(1) ? FUNC_LOCK_WR : FUNC_LOCK_RD;
          else
            func = FUNC_RELEASE;
        end else if (pick < 90) begin
          func = FUNC_INVALID;
          id   = $urandom();
        end else if (pick < 94) begin
          func = FUNC_W'($urandom_range(3));
          id   = FILEID_FREE;
        end else begin
          func = FUNC_W'($urandom_range(2));
          id   = $urandom();
        end
        send_request(func, id);
      end
      settle();
    end

    if (fails == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #40ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/rlst_pkg.sv
rtl/core/rlst_req_if.sv
rtl/core/rlst_rsp_if.sv
rtl/core/rlst_ctrl.sv
rtl/core/rlst_dp.sv
rtl/core/refcounted_lock_slot_table.sv
tb/rlst_checker.sv
tb/refcounted_lock_slot_table_tb.sv
